[src/dcc_pkg.sv]
// Shared types, constants and helper functions for the DCC track signal generator.
// No dependencies; the interfaces and the top level use it through scoped names.

package dcc_pkg;

  // frame geometry
  localparam int unsigned MAX_PACKET_BYTES = 7;
  localparam int unsigned PREAMBLE_BITS    = 16;
  localparam int unsigned CHAR_BITS        = 9;   // start bit plus eight data bits
  localparam int unsigned GAP_TICKS        = 2;

  // counter and index widths
  localparam int unsigned CNT_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_PACKET_BYTES);
  localparam int unsigned BITS_W = $clog2(PREAMBLE_BITS + 1);
  localparam int unsigned HALF_W = 14;
  localparam int unsigned TIME_W = 11;
  localparam int unsigned CUT_W  = 10;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ONE_HALF    = 3'd0,
    REG_ZERO_HALF   = 3'd1,
    REG_POWER_EN    = 3'd2,
    REG_CUT_DELAY   = 3'd3,
    REG_CUT_SHORT   = 3'd4
  } cfg_reg_e;

  // register reset values
  localparam logic [HALF_W-1:0] ONE_HALF_RST  = HALF_W'(58);
  localparam logic [HALF_W-1:0] ZERO_HALF_RST = HALF_W'(100);
  localparam logic [CUT_W-1:0]  CUT_DELAY_RST = CUT_W'(28);
  localparam logic [CUT_W-1:0]  CUT_SHORT_RST = CUT_W'(439);

  // frame phase, one-hot
  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'b001,
    PH_DATA     = 3'b010,
    PH_END      = 3'b100
  } phase_e;

  // result item
  typedef struct packed {
    logic track_level;
    logic power_out;
    logic cutout_short;
    logic write_rejected;
    logic packet_pending;
  } result_t;

  // idle packet FF 00 FF
  localparam logic [CNT_W-1:0] IDLE_LEN = CNT_W'(3);

  function automatic logic [7:0] idle_byte(input logic [CNT_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      CNT_W'(0): b = 8'hFF;
      CNT_W'(1): b = 8'h00;
      CNT_W'(2): b = 8'hFF;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[src/dcc_if.sv]
// Valid/ready channel interfaces for the DCC track signal generator.
// Depends on dcc_pkg for the configuration field widths.

// input transaction: tick or packet byte write
interface dcc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, cmd, packet_byte, last_byte, input ready);
  modport sink   (input valid, cmd, packet_byte, last_byte, output ready);
endinterface

// result transaction: track levels and write status
interface dcc_out_if;
  logic valid;
  logic ready;
  logic track_level;
  logic power_out;
  logic cutout_short;
  logic write_rejected;
  logic packet_pending;

  modport source (output valid, track_level, power_out, cutout_short,
                  write_rejected, packet_pending, input ready);
  modport sink   (input valid, track_level, power_out, cutout_short,
                  write_rejected, packet_pending, output ready);
endinterface

// configuration write transaction
interface dcc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dcc_pkg::CFG_IDX_W-1:0]    index;
  logic [dcc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/dcc_track_signal_generator.sv]
// DCC track waveform generator with RailCom cutout: each transaction's result is
// registered and shown in the next cycle; one transaction accepted every cycle while the
// result register is empty or being drained (a single output register).
// Reset starts a frame at the preamble, empties the packet store, loads the
// default bit timing and cutout settings; store contents are undefined until written.
// Depends on dcc_pkg and the interfaces in dcc_if.sv.

module dcc_track_signal_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  dcc_in_if.sink        in_i,
  dcc_out_if.source     out_o,
  dcc_cfg_if.sink       cfg_i
);

  localparam int unsigned CntW  = dcc_pkg::CNT_W;
  localparam int unsigned IdxW  = dcc_pkg::IDX_W;
  localparam int unsigned BitsW = dcc_pkg::BITS_W;
  localparam int unsigned HalfW = dcc_pkg::HALF_W;
  localparam int unsigned TimeW = dcc_pkg::TIME_W;
  localparam int unsigned CutW  = dcc_pkg::CUT_W;

  // configuration registers
  logic [HalfW-1:0] one_half_q, zero_half_q;
  logic             power_en_q;
  logic [CutW-1:0]  cut_delay_q, cut_short_q;

  // frame state
  logic [7:0]          store_q [dcc_pkg::MAX_PACKET_BYTES];
  logic [CntW-1:0]     stored_count_q, stored_count_d;
  logic                packet_ready_q, packet_ready_d;
  dcc_pkg::phase_e     phase_q, phase_d;
  logic [BitsW-1:0]    bits_left_q, bits_left_d;
  logic                cur_bit_q, cur_bit_d;
  logic                second_half_q, second_half_d;
  logic [HalfW-1:0]    half_cnt_q, half_cnt_d;
  logic [TimeW-1:0]    frame_time_q, frame_time_d;
  logic [7:0]          shift_q, shift_d;
  logic [CntW-1:0]     byte_idx_q, byte_idx_d;
  logic                sending_idle_q, sending_idle_d;

  // output register
  logic                out_valid_q;
  dcc_pkg::result_t    res_q, res_d;

  logic in_fire, tick, wr, store_we;

  // configuration writes, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_half_q  <= dcc_pkg::ONE_HALF_RST;
      zero_half_q <= dcc_pkg::ZERO_HALF_RST;
      power_en_q  <= 1'b1;
      cut_delay_q <= dcc_pkg::CUT_DELAY_RST;
      cut_short_q <= dcc_pkg::CUT_SHORT_RST;
    end else if (cfg_i.valid) begin
      case (dcc_pkg::cfg_reg_e'(cfg_i.index))
        dcc_pkg::REG_ONE_HALF:  one_half_q  <= cfg_i.data;
        dcc_pkg::REG_ZERO_HALF: zero_half_q <= cfg_i.data;
        dcc_pkg::REG_POWER_EN:  power_en_q  <= cfg_i.data[0];
        dcc_pkg::REG_CUT_DELAY: cut_delay_q <= cfg_i.data[CutW-1:0];
        dcc_pkg::REG_CUT_SHORT: cut_short_q <= cfg_i.data[CutW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign tick       = in_fire && !in_i.cmd;
  assign wr         = in_fire && in_i.cmd;

  // cutout window from frame time
  logic [TimeW:0] t_ext, d_ext, s_ext;
  logic           pre, pwr_off, short_on;

  always_comb begin
    t_ext    = {1'b0, frame_time_q};
    d_ext    = (TimeW+1)'(cut_delay_q);
    s_ext    = (TimeW+1)'(cut_short_q);
    pre      = (phase_q == dcc_pkg::PH_PREAMBLE);
    pwr_off  = pre && (t_ext >= d_ext) &&
               (t_ext < d_ext + s_ext + (TimeW+1)'(2 * dcc_pkg::GAP_TICKS));
    short_on = pre && (t_ext >= d_ext + (TimeW+1)'(dcc_pkg::GAP_TICKS)) &&
               (t_ext < d_ext + (TimeW+1)'(dcc_pkg::GAP_TICKS) + s_ext);
  end

  // byte fetch for the next character
  logic            idle_new, load_idle;
  logic [CntW-1:0] idx_next, rd_idx, load_len;
  logic [7:0]      load_byte;
  logic [HalfW:0]  half_inc;
  logic [HalfW-1:0] half_len;
  logic [BitsW-1:0] bits_dec;
  logic             half_done;

  always_comb begin
    idle_new  = !(packet_ready_q && (stored_count_q != '0));
    load_idle = pre ? idle_new : sending_idle_q;
    idx_next  = byte_idx_q + CntW'(1);
    rd_idx    = pre ? '0 : idx_next;
    load_len  = load_idle ? dcc_pkg::IDLE_LEN : stored_count_q;
    load_byte = load_idle ? dcc_pkg::idle_byte(rd_idx) : store_q[rd_idx[IdxW-1:0]];
    half_len  = cur_bit_q ? one_half_q : zero_half_q;
    half_inc  = {1'b0, half_cnt_q} + (HalfW+1)'(1);
    half_done = (half_inc >= {1'b0, half_len});
    bits_dec  = (bits_left_q != '0) ? bits_left_q - BitsW'(1) : bits_left_q;
  end

  // next state and result
  always_comb begin
    stored_count_d = stored_count_q;
    packet_ready_d = packet_ready_q;
    phase_d        = phase_q;
    bits_left_d    = bits_left_q;
    cur_bit_d      = cur_bit_q;
    second_half_d  = second_half_q;
    half_cnt_d     = half_cnt_q;
    frame_time_d   = frame_time_q;
    shift_d        = shift_q;
    byte_idx_d     = byte_idx_q;
    sending_idle_d = sending_idle_q;
    store_we       = 1'b0;

    res_d.track_level    = !second_half_q;
    res_d.power_out      = pwr_off ? 1'b0 : power_en_q;
    res_d.cutout_short   = short_on;
    res_d.write_rejected = 1'b0;

    // packet byte write
    if (wr) begin
      if (packet_ready_q) begin
        res_d.write_rejected = 1'b1;
      end else if (stored_count_q >= CntW'(dcc_pkg::MAX_PACKET_BYTES)) begin
        res_d.write_rejected = 1'b1;
        stored_count_d       = '0;
      end else begin
        store_we       = 1'b1;
        stored_count_d = stored_count_q + CntW'(1);
        if (in_i.last_byte) packet_ready_d = 1'b1;
      end
    end

    // time tick
    if (tick) begin
      if (frame_time_q != '1) frame_time_d = frame_time_q + TimeW'(1);
      if (!half_done) begin
        half_cnt_d = half_inc[HalfW-1:0];
      end else begin
        half_cnt_d = '0;
        if (!second_half_q) begin
          second_half_d = 1'b1;
        end else begin
          second_half_d = 1'b0;
          bits_left_d   = bits_dec;
          case (phase_q)
            dcc_pkg::PH_PREAMBLE: begin
              if (bits_dec == '0) begin
                sending_idle_d = idle_new;
                phase_d        = dcc_pkg::PH_DATA;
                byte_idx_d     = '0;
                shift_d        = load_byte;
                bits_left_d    = BitsW'(dcc_pkg::CHAR_BITS);
                cur_bit_d      = 1'b0;
              end
            end
            dcc_pkg::PH_DATA: begin
              if (bits_dec != '0) begin
                cur_bit_d = shift_q[7];
                shift_d   = {shift_q[6:0], 1'b0};
              end else begin
                byte_idx_d = idx_next;
                if (idx_next < load_len) begin
                  shift_d     = load_byte;
                  bits_left_d = BitsW'(dcc_pkg::CHAR_BITS);
                  cur_bit_d   = 1'b0;
                end else begin
                  phase_d     = dcc_pkg::PH_END;
                  bits_left_d = BitsW'(1);
                  cur_bit_d   = 1'b1;
                end
              end
            end
            default: begin
              // closing bit done: retire the stored packet unless idle was sent, restart the preamble
              if (!sending_idle_q) begin
                packet_ready_d = 1'b0;
                stored_count_d = '0;
              end
              phase_d      = dcc_pkg::PH_PREAMBLE;
              bits_left_d  = BitsW'(dcc_pkg::PREAMBLE_BITS);
              cur_bit_d    = 1'b1;
              frame_time_d = '0;
            end
          endcase
        end
      end
    end

    // pending flag: after the write, before the tick
    res_d.packet_pending = wr ? packet_ready_d : packet_ready_q;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_count_q <= '0;
      packet_ready_q <= 1'b0;
      phase_q        <= dcc_pkg::PH_PREAMBLE;
      bits_left_q    <= BitsW'(dcc_pkg::PREAMBLE_BITS);
      cur_bit_q      <= 1'b1;
      second_half_q  <= 1'b0;
      half_cnt_q     <= '0;
      frame_time_q   <= '0;
      shift_q        <= '0;
      byte_idx_q     <= '0;
      sending_idle_q <= 1'b0;
    end else begin
      stored_count_q <= stored_count_d;
      packet_ready_q <= packet_ready_d;
      phase_q        <= phase_d;
      bits_left_q    <= bits_left_d;
      cur_bit_q      <= cur_bit_d;
      second_half_q  <= second_half_d;
      half_cnt_q     <= half_cnt_d;
      frame_time_q   <= frame_time_d;
      shift_q        <= shift_d;
      byte_idx_q     <= byte_idx_d;
      sending_idle_q <= sending_idle_d;
    end
  end

  // packet store
  always_ff @(posedge clk_i) begin
    if (store_we) store_q[stored_count_q[IdxW-1:0]] <= in_i.packet_byte;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) res_q <= res_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.track_level    = res_q.track_level;
  assign out_o.power_out      = res_q.power_out;
  assign out_o.cutout_short   = res_q.cutout_short;
  assign out_o.write_rejected = res_q.write_rejected;
  assign out_o.packet_pending = res_q.packet_pending;

  // store fill never exceeds capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_count_q <= CntW'(dcc_pkg::MAX_PACKET_BYTES))
    else $error("stored byte count beyond capacity");

  // a complete packet always holds at least one byte
  a_ready_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    packet_ready_q |-> (stored_count_q != '0))
    else $error("packet ready with empty store");

  // data phase never points past the frame
  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == dcc_pkg::PH_DATA) |->
      (byte_idx_q < (sending_idle_q ? dcc_pkg::IDLE_LEN : stored_count_q)))
    else $error("byte index beyond frame length");

  // short only while power is off
  a_short_unpowered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.cutout_short) |-> !res_q.power_out)
    else $error("short applied with track power on");

  // a tick result never reports a rejected write
  a_tick_no_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> !res_q.write_rejected)
    else $error("rejection flagged on a tick");

endmodule
